>>> hdl/cpf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package cpf_pkg;

  localparam logic [7:0] HdrHi = 8'hEF;
  localparam logic [7:0] HdrLo = 8'h01;
  localparam logic [31:0] AddrReset = 32'hFFFF_FFFF;
  localparam logic [7:0] FlagReset = 8'h01;

  localparam logic [0:0] RegDeviceAddress = 1'd0;
  localparam logic [0:0] RegPacketFlag = 1'd1;

  typedef struct packed {
    logic [7:0] payload_byte;
    logic       first_byte;
    logic       final_byte;
    logic [7:0] payload_count;
  } in_word_t;

  typedef struct packed {
    logic [7:0] tx_byte;
    logic       packet_end;
    logic       run_last;
  } out_word_t;

  typedef struct packed {
    logic [31:0] device_address;
    logic [7:0]  packet_flag;
  } cfg_t;

  typedef enum logic [3:0] {
    POS_HDR_HI  = 4'd0,
    POS_HDR_LO  = 4'd1,
    POS_ADDR_3  = 4'd2,
    POS_ADDR_2  = 4'd3,
    POS_ADDR_1  = 4'd4,
    POS_ADDR_0  = 4'd5,
    POS_FLAG    = 4'd6,
    POS_LEN_HI  = 4'd7,
    POS_LEN_LO  = 4'd8,
    POS_DATA    = 4'd9,
    POS_SUM_HI  = 4'd10,
    POS_SUM_LO  = 4'd11
  } pos_e;

endpackage

`default_nettype wire

>>> hdl/cpf_out_reg.sv
`timescale 1ns / 1ps
`default_nettype none

module cpf_out_reg (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire cpf_pkg::out_word_t in_word_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output cpf_pkg::out_word_t     out_word_o
);
  import cpf_pkg::*;

  logic      valid_q, valid_d;
  out_word_t word_q;

  assign in_ready_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (in_ready_o) begin
      valid_d = in_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      word_q <= in_word_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_word_o  = word_q;

endmodule

`default_nettype wire

>>> hdl/cpf_frame_seq.sv
`timescale 1ns / 1ps
`default_nettype none

module cpf_frame_seq (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire cpf_pkg::cfg_t      cfg_i,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire cpf_pkg::in_word_t  in_word_i,
  output logic                    emit_valid_o,
  input  wire logic               emit_ready_i,
  output cpf_pkg::out_word_t      emit_word_o
);
  import cpf_pkg::*;

  logic        hold_valid_q, hold_valid_d;
  in_word_t    hold_q;
  pos_e        pos_q, pos_d;
  logic [15:0] running_sum_q, running_sum_d;
  logic        in_packet_q, in_packet_d;

  logic        step;
  logic        done_now;
  logic        accept;
  logic        load;
  pos_e        pos_next;
  logic [15:0] len;

  assign len  = {8'd0, hold_q.payload_count} + 16'd2;
  assign step = hold_valid_q && emit_ready_i;

  always_comb begin
    done_now = 1'b0;
    pos_next = pos_q;
    case (pos_q)
      POS_HDR_HI: pos_next = POS_HDR_LO;
      POS_HDR_LO: pos_next = POS_ADDR_3;
      POS_ADDR_3: pos_next = POS_ADDR_2;
      POS_ADDR_2: pos_next = POS_ADDR_1;
      POS_ADDR_1: pos_next = POS_ADDR_0;
      POS_ADDR_0: pos_next = POS_FLAG;
      POS_FLAG:   pos_next = POS_LEN_HI;
      POS_LEN_HI: pos_next = POS_LEN_LO;
      POS_LEN_LO: pos_next = POS_DATA;
      POS_DATA: begin
        if (hold_q.final_byte) begin
          pos_next = POS_SUM_HI;
        end else begin
          done_now = 1'b1;
        end
      end
      POS_SUM_HI: pos_next = POS_SUM_LO;
      POS_SUM_LO: done_now = 1'b1;
      default:    done_now = 1'b1;
    endcase
  end

  always_comb begin
    emit_word_o = '0;
    case (pos_q)
      POS_HDR_HI: emit_word_o.tx_byte = HdrHi;
      POS_HDR_LO: emit_word_o.tx_byte = HdrLo;
      POS_ADDR_3: emit_word_o.tx_byte = cfg_i.device_address[31:24];
      POS_ADDR_2: emit_word_o.tx_byte = cfg_i.device_address[23:16];
      POS_ADDR_1: emit_word_o.tx_byte = cfg_i.device_address[15:8];
      POS_ADDR_0: emit_word_o.tx_byte = cfg_i.device_address[7:0];
      POS_FLAG:   emit_word_o.tx_byte = cfg_i.packet_flag;
      POS_LEN_HI: emit_word_o.tx_byte = len[15:8];
      POS_LEN_LO: emit_word_o.tx_byte = len[7:0];
      POS_DATA: begin
        emit_word_o.tx_byte  = hold_q.payload_byte;
        emit_word_o.run_last = !hold_q.final_byte;
      end
      POS_SUM_HI: emit_word_o.tx_byte = running_sum_q[15:8];
      POS_SUM_LO: begin
        emit_word_o.tx_byte    = running_sum_q[7:0];
        emit_word_o.packet_end = 1'b1;
        emit_word_o.run_last   = 1'b1;
      end
      default: emit_word_o = '0;
    endcase
  end

  assign emit_valid_o = hold_valid_q;
  assign in_ready_o   = !hold_valid_q || (step && done_now);
  assign accept       = in_valid_i && in_ready_o;
  // a non-opening word while idle is dropped
  assign load         = accept && (in_word_i.first_byte || in_packet_q);

  always_comb begin
    hold_valid_d  = hold_valid_q;
    pos_d         = pos_q;
    running_sum_d = running_sum_q;
    in_packet_d   = in_packet_q;
    if (step) begin
      pos_d = pos_next;
      if (done_now) begin
        hold_valid_d = 1'b0;
      end
      case (pos_q)
        POS_LEN_LO: running_sum_d = {8'd0, cfg_i.packet_flag} + {8'd0, len[15:8]}
                                    + {8'd0, len[7:0]};
        POS_DATA:   running_sum_d = running_sum_q + {8'd0, hold_q.payload_byte};
        POS_SUM_LO: running_sum_d = '0;
        default:    running_sum_d = running_sum_q;
      endcase
    end
    if (load) begin
      hold_valid_d = 1'b1;
      pos_d        = in_word_i.first_byte ? POS_HDR_HI : POS_DATA;
      in_packet_d  = !in_word_i.final_byte;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_valid_q  <= 1'b0;
      pos_q         <= POS_HDR_HI;
      running_sum_q <= '0;
      in_packet_q   <= 1'b0;
    end else begin
      hold_valid_q  <= hold_valid_d;
      pos_q         <= pos_d;
      running_sum_q <= running_sum_d;
      in_packet_q   <= in_packet_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      hold_q <= in_word_i;
    end
  end

`ifndef SYNTHESIS
  a_cont_skips_header: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (hold_valid_q && !hold_q.first_byte) |-> (pos_q >= POS_DATA))
    else $error("continuation word framed with header");
  a_sum_needs_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (hold_valid_q && (pos_q == POS_SUM_HI || pos_q == POS_SUM_LO)) |->
    hold_q.final_byte)
    else $error("checksum emitted without final byte");
  a_sum_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step && pos_q == POS_SUM_LO) |=> (running_sum_q == 16'd0))
    else $error("running sum not cleared after packet end");
  a_end_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (hold_valid_q && emit_word_o.packet_end) |-> emit_word_o.run_last)
    else $error("packet end not marked as last word of run");
`endif

endmodule

`default_nettype wire

>>> hdl/command_packet_framer.sv
// an input word waits in the sequencer's hold register; its bytes then pass the output
// register. A mid-packet word frames to 1 byte, an opening word to 10, a closing word to 3,
// and an opening word that also closes the packet to 12 bytes; the byte sequencer emits
// one word per cycle unless stalled, and holds its input until its last byte goes out
// reset: device address 0xFFFFFFFF, packet flag 1, running sum cleared, no packet open
`timescale 1ns / 1ps
`default_nettype none

module command_packet_framer (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [0:0]         cfg_index_i,
  input  wire logic [31:0]        cfg_data_i,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire cpf_pkg::in_word_t  in_word_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output cpf_pkg::out_word_t      out_word_o
);
  import cpf_pkg::*;

  cfg_t      cfg_q, cfg_d;
  logic      emit_valid;
  logic      emit_ready;
  out_word_t emit_word;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        RegDeviceAddress: cfg_d.device_address = cfg_data_i;
        RegPacketFlag:    cfg_d.packet_flag = cfg_data_i[7:0];
        default:          cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.device_address <= AddrReset;
      cfg_q.packet_flag    <= FlagReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  cpf_frame_seq u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_word_i    (in_word_i),
    .emit_valid_o (emit_valid),
    .emit_ready_i (emit_ready),
    .emit_word_o  (emit_word)
  );

  cpf_out_reg u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (emit_valid),
    .in_ready_o  (emit_ready),
    .in_word_i   (emit_word),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_word_o  (out_word_o)
  );

endmodule

`default_nettype wire

>>> test/cpf_stream_checker.sv
`timescale 1ns / 1ps

module cpf_stream_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  input  logic               cfg_ready_i,
  input  logic [0:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  cpf_pkg::in_word_t  in_word_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  cpf_pkg::out_word_t out_word_i,
  output int unsigned        errors_o,
  output int unsigned        pending_o,
  output int unsigned        packets_o,
  output int unsigned        bytes_o
);
  import cpf_pkg::*;

  logic [31:0] dev_addr;
  logic [7:0]  pkt_flag;
  logic [15:0] sum_acc;
  logic        pkt_open;
  out_word_t   framed_q[$];
  int unsigned err_cnt = 0;
  int unsigned pkt_cnt = 0;
  int unsigned byte_cnt = 0;

  function automatic out_word_t tx(input logic [7:0] b, input logic fin);
    out_word_t w;
    w.tx_byte    = b;
    w.packet_end = fin;
    w.run_last   = 1'b0;
    return w;
  endfunction

  task automatic frame_word(input in_word_t w);
    out_word_t   burst[$];
    out_word_t   nxt;
    logic [15:0] len;
    if (!w.first_byte && !pkt_open) begin
      return;
    end
    if (w.first_byte) begin
      len = {8'd0, w.payload_count} + 16'd2;
      burst.push_back(tx(HdrHi, 1'b0));
      burst.push_back(tx(HdrLo, 1'b0));
      burst.push_back(tx(dev_addr[31:24], 1'b0));
      burst.push_back(tx(dev_addr[23:16], 1'b0));
      burst.push_back(tx(dev_addr[15:8], 1'b0));
      burst.push_back(tx(dev_addr[7:0], 1'b0));
      burst.push_back(tx(pkt_flag, 1'b0));
      burst.push_back(tx(len[15:8], 1'b0));
      burst.push_back(tx(len[7:0], 1'b0));
      sum_acc = {8'd0, pkt_flag} + {8'd0, len[15:8]} + {8'd0, len[7:0]};
      pkt_open = 1'b1;
    end
    burst.push_back(tx(w.payload_byte, 1'b0));
    sum_acc = sum_acc + {8'd0, w.payload_byte};
    if (w.final_byte) begin
      burst.push_back(tx(sum_acc[15:8], 1'b0));
      burst.push_back(tx(sum_acc[7:0], 1'b1));
      sum_acc  = '0;
      pkt_open = 1'b0;
    end
    foreach (burst[i]) begin
      nxt = burst[i];
      nxt.run_last = (i == burst.size() - 1);
      framed_q.push_back(nxt);
    end
  endtask

  task automatic check_word(input out_word_t got);
    out_word_t want;
    byte_cnt++;
    if (got.packet_end === 1'b1) begin
      pkt_cnt++;
    end
    if (framed_q.size() == 0) begin
      if (err_cnt < 10) begin
        $display("unexpected word: byte %h end %b last %b",
                 got.tx_byte, got.packet_end, got.run_last);
      end
      err_cnt++;
      return;
    end
    want = framed_q.pop_front();
    if (got.tx_byte !== want.tx_byte || got.packet_end !== want.packet_end ||
        got.run_last !== want.run_last) begin
      if (err_cnt < 10) begin
        $display("mismatch: expected byte %h end %b last %b, got byte %h end %b last %b",
                 want.tx_byte, want.packet_end, want.run_last,
                 got.tx_byte, got.packet_end, got.run_last);
      end
      err_cnt++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dev_addr = AddrReset;
      pkt_flag = FlagReset;
      sum_acc  = '0;
      pkt_open = 1'b0;
      framed_q.delete();
    end else begin
      if (out_valid_i && out_ready_i) begin
        check_word(out_word_i);
      end
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_index_i == RegDeviceAddress) begin
          dev_addr = cfg_data_i;
        end else if (cfg_index_i == RegPacketFlag) begin
          pkt_flag = cfg_data_i[7:0];
        end
      end
      if (in_valid_i && in_ready_i) begin
        frame_word(in_word_i);
      end
    end
    errors_o  <= err_cnt;
    pending_o <= framed_q.size();
    packets_o <= pkt_cnt;
    bytes_o   <= byte_cnt;
  end

endmodule

>>> test/tb_command_packet_framer.sv
`timescale 1ns / 1ps

module tb_command_packet_framer;
  import cpf_pkg::*;

  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned DrainCycles = 20;
  localparam int unsigned HoldCycles  = 300;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [0:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_word_t    in_word = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_word_t   out_word;
  logic        rx_hold = 1'b0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned cycles = 0;
  int unsigned words_taken = 0;
  int unsigned errors;
  int unsigned pending;
  int unsigned packets;
  int unsigned bytes_seen;

  command_packet_framer dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_word_i   (in_word),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_word_o  (out_word)
  );

  cpf_stream_checker checker_i (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_i (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_ready_i  (in_ready),
    .in_word_i   (in_word),
    .out_valid_i (out_valid),
    .out_ready_i (out_ready),
    .out_word_i  (out_word),
    .errors_o    (errors),
    .pending_o   (pending),
    .packets_o   (packets),
    .bytes_o     (bytes_seen)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_ready <= !rx_hold && ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  function automatic in_word_t word_of(input logic [7:0] data, input logic first,
                                       input logic fin, input logic [7:0] count);
    in_word_t w;
    w.payload_byte  = data;
    w.first_byte    = first;
    w.final_byte    = fin;
    w.payload_count = count;
    return w;
  endfunction

  task automatic put_word(input in_word_t w);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    do @(posedge clk); while (!in_ready);
    words_taken++;
  endtask

  task automatic send_packet(input int unsigned nbytes, input logic [7:0] count,
                             input logic closed);
    for (int i = 0; i < nbytes; i++) begin
      put_word(word_of(8'($urandom_range(255)), i == 0, closed && (i == nbytes - 1),
                       (i == 0) ? count : 8'($urandom_range(255))));
    end
  endtask

  task automatic run_phase(input int unsigned target);
    int unsigned sent;
    int unsigned pick;
    int unsigned n;
    logic [7:0]  count;
    sent = 0;
    while (sent < target) begin
      pick  = $urandom_range(99);
      n     = ($urandom_range(9) == 0) ? $urandom_range(40, 9) : $urandom_range(8, 1);
      count = ($urandom_range(3) == 0) ? 8'($urandom_range(255)) : 8'(n);
      if (pick < 8) begin
        // stray byte, mostly between packets
        put_word(word_of(8'($urandom_range(255)), 1'b0, 1'($urandom_range(1)),
                         8'($urandom_range(255))));
      end else if (pick < 16) begin
        send_packet(n, count, 1'b0);
        sent += n;
      end else begin
        send_packet(n, count, 1'b1);
        sent += n;
      end
    end
    in_valid <= 1'b0;
  endtask

  task automatic settle_cfg(input logic [31:0] addr, input logic [7:0] flag);
    do @(posedge clk); while (pending != 0);
    repeat (8) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= RegDeviceAddress;
    cfg_data  <= addr;
    do @(posedge clk); while (!cfg_ready);
    cfg_index <= RegPacketFlag;
    cfg_data  <= {24'd0, flag};
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    send_idle_pct <= 19;
    recv_idle_pct <= 55;

    // one-byte packet with zero count
    put_word(word_of(8'h00, 1'b1, 1'b1, 8'h00));
    // bytes with no open packet
    put_word(word_of(8'h5A, 1'b0, 1'b0, 8'hFF));
    put_word(word_of(8'hA5, 1'b0, 1'b1, 8'h00));
    // largest count, short body
    put_word(word_of(8'hFF, 1'b1, 1'b0, 8'hFF));
    put_word(word_of(8'hAA, 1'b0, 1'b0, 8'h00));
    put_word(word_of(8'h55, 1'b0, 1'b1, 8'h00));
    // packet cut off by a new opening word
    put_word(word_of(8'h01, 1'b1, 1'b0, 8'h03));
    put_word(word_of(8'h02, 1'b0, 1'b0, 8'h03));
    put_word(word_of(8'h80, 1'b1, 1'b0, 8'hFE));
    put_word(word_of(8'h7F, 1'b0, 1'b1, 8'h01));
    put_word(word_of(8'hFF, 1'b1, 1'b1, 8'hFF));
    // checksum carry
    for (int i = 0; i < 6; i++) begin
      put_word(word_of(8'hFF, i == 0, i == 5, 8'd6));
    end
    run_phase(105);

    settle_cfg(32'h0000_0000, 8'h00);
    send_idle_pct <= 55;
    recv_idle_pct <= 19;
    run_phase(110);

    settle_cfg($urandom, 8'hFF);
    send_idle_pct <= 0;
    recv_idle_pct <= 0;
    fork
      begin
        rx_hold <= 1'b1;
        repeat (HoldCycles) @(posedge clk);
        rx_hold <= 1'b0;
      end
    join_none
    run_phase(110);

    do @(posedge clk); while (pending != 0);
    repeat (DrainCycles) @(posedge clk);
    $display("%0d input words sent, %0d bytes framed, %0d packets closed", words_taken,
             bytes_seen, packets);
    $display("three address and flag settings, three idle mixes, one long output stall");
    if (errors == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
hdl/cpf_pkg.sv
hdl/cpf_out_reg.sv
hdl/cpf_frame_seq.sv
hdl/command_packet_framer.sv
test/cpf_stream_checker.sv
test/tb_command_packet_framer.sv
